[sv/tbs_pkg.sv]
// Shared types and constants of the token bucket shaper.
`default_nettype none
package tbs_pkg;

	localparam int RATE_W    = 29;
	localparam int LAT_W     = 16;
	localparam int LIMIT_W   = 32;
	localparam int LEN_W     = 16;
	localparam int CFG_AW    = 2;
	localparam int CFG_DW    = 32;
	localparam int OUT_W     = 120;

	// divider: 1e6 * size needs 36 bits, the divisor (rate or unit size) fits in RATE_W bits
	localparam int DIV_NW    = 36;
	localparam int DIV_DW    = RATE_W;
	localparam int DIV_CW    = $clog2(DIV_NW + 1);
	localparam int LAT_PW    = DIV_DW + LAT_W;

	localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;
	localparam logic [RATE_W-1:0]  RATE_RESET   = 29'd125000;
	localparam logic [LAT_W-1:0]   LAT_RESET    = 16'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 32'd65536;

	typedef enum logic [CFG_AW-1:0] {
		CFG_RATE    = 2'd0,
		CFG_LATENCY = 2'd1,
		CFG_LIMIT   = 2'd2
	} tbs_cfg_addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV_INT,
		ST_DIV_LAT,
		ST_RESULT
	} tbs_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} tbs_div_req_t;

endpackage
`default_nettype wire

[sv/token_bucket_shaper_unit.sv]
// Token bucket shaper: admission and release decisions for a packet queue.
// Input stream: s_tuser is the op (0 enqueue, 1 dequeue attempt), s_tdata carries
// the packet length and the current time in microseconds. One result item comes
// back on the m_ stream for each input item: accepted flag, queued bytes, drop
// count, limit in force and the current unit size.
// A plain item is accepted in ST_IDLE and decided in ST_EXEC; the result is then
// registered in the output register. An enqueue that raises the unit size reruns
// the interval division on the shared one-bit-per-cycle divider; in latency mode
// a second division derives the limit. A configuration write triggers the same
// derivation, during which s_tready is low; a write during it queues one more pass.
// Reset restores the register defaults, an empty queue and the initial size;
// the reset interval and limit are constants, so the block is ready at once.
// When the receiver stalls, the result waits in the output register and the
// block holds the next result in ST_RESULT until the register frees up.
`default_nettype none
module token_bucket_shaper_unit #(
	parameter int TIME_WIDTH   = 48,
	parameter int INITIAL_SIZE = 1000
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// pkt_len [15:0], now_us [16 +: TIME_WIDTH], zero pad
	input  wire logic [((16+TIME_WIDTH+7)/8)*8-1:0]    s_tdata,
	// op
	input  wire logic                                  s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// accepted, queue_bytes, drop_count, current_limit, current_size, zero pad
	output logic [tbs_pkg::OUT_W-1:0]                  m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [tbs_pkg::CFG_AW-1:0]            cfg_addr,
	input  wire logic [tbs_pkg::CFG_DW-1:0]            cfg_wdata
);
	import tbs_pkg::*;

	localparam logic [63:0] RESET_IVL_W =
		64'(USEC_PER_SEC) * 64'(INITIAL_SIZE) / 64'(RATE_RESET);
	localparam logic [31:0] RESET_IVL = RESET_IVL_W[31:0];

	tbs_state_t state_q, st_d;

	logic [RATE_W-1:0]     rate_q;
	logic [LAT_W-1:0]      latency_q;
	logic [LIMIT_W-1:0]    limit_cfg_q;
	logic                  cfg_pend_q;
	logic                  cfg_hit;

	logic [31:0]           queued_q;
	logic [31:0]           limit_q;
	logic [LEN_W-1:0]      size_q;
	logic [31:0]           ivl_q;
	logic [TIME_WIDTH-1:0] last_q;
	logic [31:0]           dropped_q;
	logic                  res_pend_q;
	logic                  acc_q;

	logic                  op_q;
	logic [LEN_W-1:0]      len_q;
	logic [TIME_WIDTH-1:0] now_q;

	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	tbs_div_req_t          div_req;
	logic                  div_busy;
	logic [DIV_NW-1:0]     div_quo;

	logic [RATE_W-1:0]     eff_rate;
	logic [LEN_W-1:0]      eff_size;
	logic                  enq_ok;
	logic                  grow;
	logic                  rel_ok;
	logic [TIME_WIDTH:0]   rel_sum;
	logic [32:0]           q_sum;
	logic [31:0]           q_add;
	logic [31:0]           q_sub;
	logic                  nxt_acc;
	logic [31:0]           nxt_queued;
	logic [31:0]           nxt_dropped;
	logic [LEN_W-1:0]      nxt_size;
	logic                  nxt_last_ld;
	logic [31:0]           ivl_new;
	logic [LAT_PW-1:0]     lat_prod;
	logic [31:0]           lim_lat;
	logic                  out_free;

	logic                  item_upd;
	logic                  out_ld;
	logic                  out_nxt;
	logic                  ivl_ld;
	logic                  lim_cfg_ld;
	logic                  lim_lat_ld;
	logic                  pend_clr;
	logic                  res_set;
	logic                  res_clr;

	tbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// item decision
	always_comb begin
		eff_rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
		eff_size = (size_q == '0) ? LEN_W'(1) : size_q;
		enq_ok   = queued_q < limit_q;
		grow     = enq_ok && (len_q > size_q);
		q_sum    = {1'b0, queued_q} + 33'(len_q);
		q_add    = q_sum[32] ? '1 : q_sum[31:0];
		q_sub    = (32'(len_q) >= queued_q) ? '0 : queued_q - 32'(len_q);
		// release time at full precision; only a 64-bit time can saturate
		rel_sum  = {1'b0, last_q} + (TIME_WIDTH+1)'(ivl_q);
		rel_ok   = rel_sum[TIME_WIDTH] ? ((TIME_WIDTH == 64) && (&now_q))
		                               : (now_q >= rel_sum[TIME_WIDTH-1:0]);
		if (op_q) begin
			nxt_acc     = rel_ok;
			nxt_queued  = rel_ok ? q_sub : queued_q;
			nxt_dropped = dropped_q;
			nxt_size    = size_q;
			nxt_last_ld = rel_ok && (len_q >= size_q);
		end else begin
			nxt_acc     = enq_ok;
			nxt_queued  = enq_ok ? q_add : queued_q;
			nxt_dropped = enq_ok ? dropped_q : dropped_q + 32'd1;
			nxt_size    = grow ? len_q : size_q;
			nxt_last_ld = 1'b0;
		end
		ivl_new  = (div_quo[DIV_NW-1:32] != '0) ? '1 : div_quo[31:0];
		lat_prod = LAT_PW'(div_quo[DIV_DW-1:0]) * LAT_PW'(latency_q);
		lim_lat  = (lat_prod[LAT_PW-1:32] != '0) ? '1 : lat_prod[31:0];
		out_free = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= st_d;
		end
	end

	always_comb begin
		st_d       = state_q;
		item_upd   = 1'b0;
		out_ld     = 1'b0;
		out_nxt    = 1'b0;
		ivl_ld     = 1'b0;
		lim_cfg_ld = 1'b0;
		lim_lat_ld = 1'b0;
		pend_clr   = 1'b0;
		res_set    = 1'b0;
		res_clr    = 1'b0;
		div_req    = '0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_pend_q) begin
					pend_clr = 1'b1;
					st_d     = ST_MUL;
				end else if (s_tvalid) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				item_upd = 1'b1;
				if (!op_q && grow) begin
					res_set = 1'b1;
					st_d    = ST_MUL;
				end else if (out_free) begin
					out_ld  = 1'b1;
					out_nxt = 1'b1;
					st_d    = ST_IDLE;
				end else begin
					st_d = ST_RESULT;
				end
			end
			ST_MUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(USEC_PER_SEC) * DIV_NW'(size_q);
				div_req.divisor  = eff_rate;
				st_d             = ST_DIV_INT;
			end
			ST_DIV_INT: begin
				if (!div_busy) begin
					ivl_ld = 1'b1;
					if (latency_q != '0) begin
						div_req.start    = 1'b1;
						div_req.dividend = DIV_NW'(eff_rate);
						div_req.divisor  = DIV_DW'(eff_size);
						st_d             = ST_DIV_LAT;
					end else begin
						lim_cfg_ld = 1'b1;
						st_d       = res_pend_q ? ST_RESULT : ST_IDLE;
					end
				end
			end
			ST_DIV_LAT: begin
				if (!div_busy) begin
					lim_lat_ld = 1'b1;
					st_d       = res_pend_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					res_clr = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign cfg_hit = cfg_we && (cfg_addr inside {CFG_RATE, CFG_LATENCY, CFG_LIMIT});

	// configuration registers; any valid write reruns the derivation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RESET;
			latency_q   <= LAT_RESET;
			limit_cfg_q <= LIMIT_RESET;
			cfg_pend_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_RATE: begin
						rate_q <= cfg_wdata[RATE_W-1:0];
					end
					CFG_LATENCY: begin
						latency_q <= cfg_wdata[LAT_W-1:0];
					end
					CFG_LIMIT: begin
						limit_cfg_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (cfg_hit) begin
				cfg_pend_q <= 1'b1;
			end else if (pend_clr) begin
				cfg_pend_q <= 1'b0;
			end
		end
	end

	// shaper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q   <= '0;
			limit_q    <= LIMIT_RESET;
			size_q     <= LEN_W'(INITIAL_SIZE);
			ivl_q      <= RESET_IVL;
			last_q     <= '0;
			dropped_q  <= '0;
			res_pend_q <= 1'b0;
			acc_q      <= 1'b0;
		end else begin
			if (item_upd) begin
				queued_q  <= nxt_queued;
				dropped_q <= nxt_dropped;
				size_q    <= nxt_size;
				acc_q     <= nxt_acc;
				if (nxt_last_ld) begin
					last_q <= now_q;
				end
			end
			if (ivl_ld) begin
				ivl_q <= ivl_new;
			end
			if (lim_cfg_ld) begin
				limit_q <= limit_cfg_q;
			end
			if (lim_lat_ld) begin
				limit_q <= lim_lat;
			end
			if (res_set) begin
				res_pend_q <= 1'b1;
			end else if (res_clr) begin
				res_pend_q <= 1'b0;
			end
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			len_q <= s_tdata[LEN_W-1:0];
			now_q <= s_tdata[LEN_W +: TIME_WIDTH];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (out_nxt) begin
				m_tdata_q <= {7'd0, nxt_size, limit_q, nxt_dropped, nxt_queued, nxt_acc};
			end else begin
				m_tdata_q <= {7'd0, size_q, limit_q, dropped_q, queued_q, acc_q};
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !cfg_pend_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted item did not enter execution");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q != $past(dropped_q) |-> dropped_q == $past(dropped_q) + 32'd1)
		else $error("drop counter moved by more than one");

	a_deq_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && op_q |=> queued_q <= $past(queued_q))
		else $error("dequeue increased the queued byte count");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> div_busy)
		else $error("divider did not start");
`endif

endmodule
`default_nettype wire

[sv/tbs_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tbs_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tbs_pkg::tbs_div_req_t req,
	output logic                      busy,
	output logic [tbs_pkg::DIV_NW-1:0] quo
);
	import tbs_pkg::*;

	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// remainder stays below the divisor, so the trial value fits in DIV_DW+1 bits
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= DIV_CW'(DIV_NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;

endmodule
`default_nettype wire
